>>> design/sba_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the size-class function of the segregated bin allocator.
// No dependencies; every other design file but sba_class_mem imports this package.
package sba_pkg;

    localparam int HEAP_ADDR_BITS_DEF = 24;
    localparam int CLASS_SHIFTS_DEF   = 21;
    localparam int CHUNK_BYTES_DEF    = 2048;

    localparam int FIELD_W  = 24;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int HDR_W    = 64;
    localparam int SIZE_W   = 32;
    localparam int SLOP_CAP = 248;

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC = 2'd0,
        FN_FREE  = 2'd1,
        FN_QUERY = 2'd2,
        FN_UNDEF = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_TOO_BIG   = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_BAD       = 2'd3
    } t_status;

    localparam logic [1:0] TAG_USED = 2'd2;
    localparam logic [1:0] TAG_FREE = 2'd1;

    // Class sizes 8,16,24,32..56 step 8, then j<<i for j = 8..15 from i = 3 on.
    function automatic logic [SIZE_W-1:0] class_size(input logic [7:0] c);
        logic [7:0] k;
        logic [4:0] sh;
        logic [3:0] j;
        k  = c - 8'd7;
        sh = 5'd3 + 5'(k[7:3]);
        j  = {1'b1, k[2:0]};
        if (c < 8'd7) begin
            return SIZE_W'({c + 8'd1, 3'b000});
        end
        return SIZE_W'(j) << sh;
    endfunction

endpackage

>>> design/sba_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the segregated bin allocator.
// Depends on sba_pkg for field widths.
interface sba_req_if;
    import sba_pkg::*;
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [FIELD_W-1:0] request_size;
    logic [FIELD_W-1:0] block_address;
    modport source (output valid, func, request_size, block_address, input ready);
    modport sink   (input valid, func, request_size, block_address, output ready);
endinterface

interface sba_rsp_if;
    import sba_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  result_address;
    logic [FIELD_W-1:0]  block_bytes;
    modport source (output valid, status, result_address, block_bytes, input ready);
    modport sink   (input valid, status, result_address, block_bytes, output ready);
endinterface

>>> design/segregated_bin_allocator.sv
`timescale 1ns / 1ps
// Segregated size-class free-list allocator: sequencer, class table and header RAM.
// Depends on sba_pkg, sba_if, sba_class_mem and sba_hdr_mem.
//
// One request is handled at a time. A size query makes one header read before the response
// is presented, and a free makes one header read and one class-table read-modify-write.
// An allocate first walks the class sizes upward one class per cycle to find the fitting
// class, then pops its list head. When that list is empty a refill runs first: each
// larger class is examined with one class-table read, in a first pass upward and a second
// pass downward, and a fresh chunk is carved from the heap top if neither finds a block;
// then a search finds the class of the remainder, and one or two list pushes follow. The
// class table has a single read port. A new request is accepted as soon as the previous
// one has been handed to the response register, even while that response still waits to
// be taken. Class-table entries reset to empty lists through per-entry valid bits, so no
// clearing pass is needed; header words are undefined until written. Every
// read-modify-write to either memory finishes its write before the next read of the same
// memory is issued, so no forwarding is required.
module segregated_bin_allocator #(
    parameter int HEAP_ADDR_BITS = sba_pkg::HEAP_ADDR_BITS_DEF,
    parameter int CLASS_SHIFTS   = sba_pkg::CLASS_SHIFTS_DEF,
    parameter int CHUNK_BYTES    = sba_pkg::CHUNK_BYTES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    sba_req_if.sink   i_req,
    sba_rsp_if.source o_rsp
);
    import sba_pkg::*;

    localparam int NUM_CLASSES = 8 * CLASS_SHIFTS - 17;
    localparam int CIW         = $clog2(NUM_CLASSES);
    localparam int WI          = HEAP_ADDR_BITS - 3;   // header word index bits
    localparam int HW          = WI + 1;               // list head: word index + 1
    localparam int CLS_W       = 2 * HW + 32;

    typedef struct packed {
        logic [HW-1:0] head;
        logic [HW-1:0] free_cnt;
        logic [31:0]   served;
    } t_cls_ent;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_FIT, S_ALLOC_RD, S_ALLOC_CHK, S_SCAN_RD, S_SCAN_CHK,
        S_CARVE, S_POP_RD, S_POP_WR, S_PUSH_RD, S_PUSH_WR, S_ATMOST,
        S_HDR_RD, S_HDR_CHK, S_DONE
    } t_state;

    // Where a push returns to once its list is updated.
    typedef enum logic [1:0] { RET_SPARE, RET_ALLOC, RET_DONE } t_ret;

    t_state               r_state, n_state;
    t_ret                 r_ret, n_ret;
    logic [FUNC_W-1:0]    r_func, n_func;
    logic [FIELD_W-1:0]   r_req, n_req;
    logic [FIELD_W-1:0]   r_addr, n_addr;
    logic [FIELD_W:0]     r_need, n_need;
    logic [CIW-1:0]       r_idx, n_idx;
    logic [CIW-1:0]       r_cls, n_cls;
    logic [CIW-1:0]       r_src, n_src;
    logic                 r_pass, n_pass;
    logic                 r_refill, n_refill;
    t_cls_ent             r_ent, n_ent;
    logic [SIZE_W-1:0]    r_lsize, n_lsize;
    logic [WI-1:0]        r_blk, n_blk;
    logic [SIZE_W-1:0]    r_spare, n_spare;
    logic [CIW-1:0]       r_push_cls, n_push_cls;
    logic [WI-1:0]        r_push_idx, n_push_idx;
    logic [SIZE_W-1:0]    r_push_real, n_push_real;
    logic [CIW-1:0]       r_cls_raddr, n_cls_raddr;
    logic [WI-1:0]        r_hdr_raddr, n_hdr_raddr;
    logic [HEAP_ADDR_BITS:0] r_heap_top, n_heap_top;
    logic                 r_out_valid, n_out_valid;
    t_status              r_status, n_status;
    logic [FIELD_W-1:0]   r_res, n_res;
    logic [FIELD_W-1:0]   r_bytes, n_bytes;
    // Response register, loaded only when a finished request is handed over.
    t_status              r_rsp_status, n_rsp_status;
    logic [FIELD_W-1:0]   r_rsp_res, n_rsp_res;
    logic [FIELD_W-1:0]   r_rsp_bytes, n_rsp_bytes;

    // Memory ports.
    logic                 cls_we;
    logic [CIW-1:0]       cls_waddr;
    t_cls_ent             cls_wdata;
    logic [CLS_W-1:0]     cls_rdata;
    logic                 hdr_we;
    logic [WI-1:0]        hdr_waddr;
    logic [HDR_W-1:0]     hdr_wdata;
    logic [HDR_W-1:0]     hdr_rdata;

    sba_class_mem #(
        .DEPTH  (NUM_CLASSES),
        .WIDTH  (CLS_W),
        .ADDR_W (CIW)
    ) u_cls_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_cls_raddr),
        .i_wr_en   (cls_we),
        .i_wr_addr (cls_waddr),
        .i_wr_data (cls_wdata),
        .o_rd_data (cls_rdata)
    );

    sba_hdr_mem #(
        .ADDR_W (WI)
    ) u_hdr_mem (
        .i_clk     (i_clk),
        .i_rd_addr (r_hdr_raddr),
        .i_wr_en   (hdr_we),
        .i_wr_addr (hdr_waddr),
        .i_wr_data (hdr_wdata),
        .o_rd_data (hdr_rdata)
    );

    // Datapath terms used by the sequencer.
    t_cls_ent          cls_e;
    logic [SIZE_W-1:0] idx_size;
    logic [SIZE_W-1:0] max_size;
    logic [WI-1:0]     head_idx;
    logic [SIZE_W-1:0] pop_real;
    logic [HW-1:0]     pop_link;
    logic [32:0]       slop_diff;
    logic [7:0]        slop_val;
    logic [SIZE_W-1:0] spare_src;
    logic [32:0]       chunk;
    logic [33:0]       top_sum;
    logic              top_fail;
    logic [32:0]       addr_m8;
    logic [29:0]       addr_idx;
    logic              addr_ok;
    logic              hdr_ok;
    logic [SIZE_W-1:0] hdr_real;
    logic [31:0]       rem_sum;
    logic [32:0]       res_sum;

    assign cls_e     = t_cls_ent'(cls_rdata);
    assign idx_size  = class_size(8'(r_idx));
    assign max_size  = class_size(8'(NUM_CLASSES - 1));
    assign head_idx  = WI'(r_ent.head - HW'(1));
    assign pop_real  = hdr_rdata[31:0];
    assign pop_link  = hdr_rdata[32 +: HW];
    assign slop_diff = {1'b0, pop_real} - 33'(r_req);
    assign slop_val  = (slop_diff[32] || slop_diff[31:0] > 32'(SLOP_CAP))
                     ? 8'(SLOP_CAP) : slop_diff[7:0];
    assign spare_src = (pop_real > r_lsize) ? pop_real - r_lsize : '0;
    // Chunks are one chunk, or the class size rounded up to whole chunks.
    assign chunk     = (r_lsize < SIZE_W'(CHUNK_BYTES)) ? 33'(CHUNK_BYTES)
                     : ((33'(r_lsize) + 33'(CHUNK_BYTES - 1)) & ~33'(CHUNK_BYTES - 1));
    assign top_sum   = 34'(r_heap_top) + 34'(chunk);
    assign top_fail  = top_sum > (34'd1 << HEAP_ADDR_BITS);
    assign addr_m8   = 33'(r_addr) - 33'd8;
    assign addr_idx  = addr_m8[32:3];
    assign addr_ok   = (r_addr >= FIELD_W'(8)) && (r_addr[2:0] == 3'b000)
                     && ((addr_idx >> WI) == '0);
    assign hdr_ok    = (hdr_rdata[63:62] == TAG_USED)
                     && (hdr_rdata[39:32] < 8'(NUM_CLASSES));
    assign hdr_real  = SIZE_W'(hdr_rdata[23:0]) + SIZE_W'(hdr_rdata[31:24]);
    assign rem_sum   = 32'(r_blk) + 32'(r_lsize[31:3]);
    assign res_sum   = 33'({head_idx, 3'b000}) + 33'd8;

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_func       = r_func;
        n_req        = r_req;
        n_addr       = r_addr;
        n_need       = r_need;
        n_idx        = r_idx;
        n_cls        = r_cls;
        n_src        = r_src;
        n_pass       = r_pass;
        n_refill     = r_refill;
        n_ent        = r_ent;
        n_lsize      = r_lsize;
        n_blk        = r_blk;
        n_spare      = r_spare;
        n_push_cls   = r_push_cls;
        n_push_idx   = r_push_idx;
        n_push_real  = r_push_real;
        n_cls_raddr  = r_cls_raddr;
        n_hdr_raddr  = r_hdr_raddr;
        n_heap_top   = r_heap_top;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_status     = r_status;
        n_res        = r_res;
        n_bytes      = r_bytes;
        n_rsp_status = r_rsp_status;
        n_rsp_res    = r_rsp_res;
        n_rsp_bytes  = r_rsp_bytes;
        cls_we       = 1'b0;
        cls_waddr    = r_cls;
        cls_wdata    = r_ent;
        hdr_we       = 1'b0;
        hdr_waddr    = r_push_idx;
        hdr_wdata    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_func    = i_req.func;
                    n_req     = i_req.request_size;
                    n_addr    = i_req.block_address;
                    n_status  = ST_OK;
                    n_res     = '0;
                    n_bytes   = '0;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (t_func'(r_func))
                    FN_ALLOC: begin
                        n_need = (FIELD_W + 1)'(r_req) + (FIELD_W + 1)'(8);
                        if (SIZE_W'(n_need) > max_size) begin
                            n_status = ST_TOO_BIG;
                            n_state  = S_DONE;
                        end else begin
                            n_idx   = '0;
                            n_state = S_FIT;
                        end
                    end
                    FN_FREE, FN_QUERY: begin
                        if (t_func'(r_func) == FN_FREE && r_addr == '0) begin
                            n_state = S_DONE;
                        end else if (!addr_ok) begin
                            n_status = ST_BAD;
                            n_state  = S_DONE;
                        end else begin
                            n_hdr_raddr = addr_idx[WI-1:0];
                            n_state     = S_HDR_RD;
                        end
                    end
                    FN_UNDEF: begin
                        n_status = ST_BAD;
                        n_state  = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_FIT: begin
                // Smallest class that holds the request plus its header.
                if (idx_size >= SIZE_W'(r_need)) begin
                    n_cls       = r_idx;
                    n_cls_raddr = r_idx;
                    n_state     = S_ALLOC_RD;
                end else begin
                    n_idx = r_idx + CIW'(1);
                end
            end
            S_ALLOC_RD: n_state = S_ALLOC_CHK;
            S_ALLOC_CHK: begin
                n_ent = cls_e;
                if (cls_e.head == '0) begin
                    n_lsize = class_size(8'(r_cls));
                    if (r_cls == CIW'(NUM_CLASSES - 1)) begin
                        n_state = S_CARVE;
                    end else begin
                        n_idx       = r_cls + CIW'(1);
                        n_cls_raddr = r_cls + CIW'(1);
                        n_pass      = 1'b0;
                        n_state     = S_SCAN_RD;
                    end
                end else begin
                    n_refill    = 1'b0;
                    n_hdr_raddr = WI'(cls_e.head - HW'(1));
                    n_state     = S_POP_RD;
                end
            end
            S_SCAN_RD: n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                // First pass looks for a class with more free blocks than it has served,
                // the second pass for the largest non-empty class.
                if (cls_e.head != '0
                        && (r_pass || 32'(cls_e.free_cnt) > cls_e.served)) begin
                    n_ent       = cls_e;
                    n_src       = r_idx;
                    n_refill    = 1'b1;
                    n_hdr_raddr = WI'(cls_e.head - HW'(1));
                    n_state     = S_POP_RD;
                end else if (!r_pass) begin
                    if (r_idx == CIW'(NUM_CLASSES - 1)) begin
                        n_pass = 1'b1;
                    end else begin
                        n_idx       = r_idx + CIW'(1);
                        n_cls_raddr = r_idx + CIW'(1);
                    end
                    n_state = S_SCAN_RD;
                end else if (r_idx == r_cls + CIW'(1)) begin
                    n_state = S_CARVE;
                end else begin
                    n_idx       = r_idx - CIW'(1);
                    n_cls_raddr = r_idx - CIW'(1);
                    n_state     = S_SCAN_RD;
                end
            end
            S_CARVE: begin
                if (top_fail) begin
                    n_status = ST_EXHAUSTED;
                    n_state  = S_DONE;
                end else begin
                    n_blk       = WI'(r_heap_top >> 3);
                    n_heap_top  = (HEAP_ADDR_BITS + 1)'(top_sum);
                    n_spare     = SIZE_W'(chunk) - r_lsize;
                    n_push_cls  = r_cls;
                    n_push_idx  = WI'(r_heap_top >> 3);
                    n_push_real = r_lsize;
                    n_cls_raddr = r_cls;
                    n_ret       = RET_SPARE;
                    n_state     = S_PUSH_RD;
                end
            end
            S_POP_RD: n_state = S_POP_WR;
            S_POP_WR: begin
                cls_we             = 1'b1;
                cls_wdata.head     = pop_link;
                cls_wdata.free_cnt = r_ent.free_cnt - HW'(1);
                if (!r_refill) begin
                    cls_waddr        = r_cls;
                    cls_wdata.served = r_ent.served + 32'd1;
                    hdr_we           = 1'b1;
                    hdr_waddr        = head_idx;
                    hdr_wdata        = {TAG_USED, 22'd0, 8'(r_cls), slop_val, r_req};
                    n_res            = res_sum[FIELD_W-1:0];
                    n_state          = S_DONE;
                end else begin
                    cls_waddr   = r_src;
                    n_blk       = head_idx;
                    n_spare     = spare_src;
                    n_push_cls  = r_cls;
                    n_push_idx  = head_idx;
                    n_push_real = r_lsize;
                    n_cls_raddr = r_cls;
                    n_ret       = RET_SPARE;
                    n_state     = S_PUSH_RD;
                end
            end
            S_PUSH_RD: n_state = S_PUSH_WR;
            S_PUSH_WR: begin
                cls_we             = 1'b1;
                cls_waddr          = r_push_cls;
                cls_wdata.head     = HW'(r_push_idx) + HW'(1);
                cls_wdata.free_cnt = cls_e.free_cnt + HW'(1);
                cls_wdata.served   = cls_e.served;
                hdr_we             = 1'b1;
                hdr_waddr          = r_push_idx;
                hdr_wdata          = {TAG_FREE, 30'(cls_e.head), r_push_real};
                unique case (r_ret)
                    RET_SPARE: begin
                        if (r_spare >= SIZE_W'(8)) begin
                            n_idx   = CIW'(NUM_CLASSES - 1);
                            n_state = S_ATMOST;
                        end else begin
                            n_cls_raddr = r_cls;
                            n_state     = S_ALLOC_RD;
                        end
                    end
                    RET_ALLOC: begin
                        n_cls_raddr = r_cls;
                        n_state     = S_ALLOC_RD;
                    end
                    RET_DONE: n_state = S_DONE;
                    default:  n_state = S_DONE;
                endcase
            end
            S_ATMOST: begin
                // Largest class not exceeding the remainder, walking down.
                if (r_idx == '0 || idx_size <= r_spare) begin
                    n_push_cls  = r_idx;
                    n_push_idx  = rem_sum[WI-1:0];
                    n_push_real = r_spare;
                    n_cls_raddr = r_idx;
                    n_ret       = RET_ALLOC;
                    n_state     = S_PUSH_RD;
                end else begin
                    n_idx = r_idx - CIW'(1);
                end
            end
            S_HDR_RD: n_state = S_HDR_CHK;
            S_HDR_CHK: begin
                if (!hdr_ok) begin
                    n_status = ST_BAD;
                    n_state  = S_DONE;
                end else if (t_func'(r_func) == FN_QUERY) begin
                    n_bytes = hdr_real[FIELD_W-1:0];
                    n_state = S_DONE;
                end else begin
                    n_push_cls  = CIW'(hdr_rdata[39:32]);
                    n_push_idx  = r_hdr_raddr;
                    n_push_real = hdr_real;
                    n_cls_raddr = CIW'(hdr_rdata[39:32]);
                    n_ret       = RET_DONE;
                    n_state     = S_PUSH_RD;
                end
            end
            S_DONE: begin
                // The response register is free once its previous response is taken.
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_rsp_status = r_status;
                    n_rsp_res    = r_res;
                    n_rsp_bytes  = r_bytes;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_heap_top  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_heap_top  <= n_heap_top;
            r_out_valid <= n_out_valid;
        end
        r_ret        <= n_ret;
        r_func       <= n_func;
        r_req        <= n_req;
        r_addr       <= n_addr;
        r_need       <= n_need;
        r_idx        <= n_idx;
        r_cls        <= n_cls;
        r_src        <= n_src;
        r_pass       <= n_pass;
        r_refill     <= n_refill;
        r_ent        <= n_ent;
        r_lsize      <= n_lsize;
        r_blk        <= n_blk;
        r_spare      <= n_spare;
        r_push_cls   <= n_push_cls;
        r_push_idx   <= n_push_idx;
        r_push_real  <= n_push_real;
        r_cls_raddr  <= n_cls_raddr;
        r_hdr_raddr  <= n_hdr_raddr;
        r_status     <= n_status;
        r_res        <= n_res;
        r_bytes      <= n_bytes;
        r_rsp_status <= n_rsp_status;
        r_rsp_res    <= n_rsp_res;
        r_rsp_bytes  <= n_rsp_bytes;
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_rsp_status;
    assign o_rsp.result_address = r_rsp_res;
    assign o_rsp.block_bytes    = r_rsp_bytes;

`ifndef SYNTHESIS
    // An accepted request always goes straight to decode.
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_DECODE))
        else $error("accepted request did not enter decode");

    // The heap top only grows, in whole 8-byte words.
    a_heap_top_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CARVE)
            |=> (r_heap_top >= $past(r_heap_top)) && (r_heap_top[2:0] == 3'b000))
        else $error("heap top moved backward or lost alignment");

    // A refill scan only looks at classes above the requested one.
    a_scan_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK) |-> (r_idx > r_cls))
        else $error("refill scan reached the requested class");
`endif
endmodule

>>> design/sba_class_mem.sv
`timescale 1ns / 1ps
// Per-class list table: head, free count and served count in one synchronous RAM.
// A valid bit per entry makes never-written entries read as zero after reset.
module sba_class_mem #(
    parameter int DEPTH  = 151,
    parameter int WIDTH  = 76,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    output logic [WIDTH-1:0]  o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= r_vld[i_rd_addr];
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rvld ? r_rdata : '0;
endmodule

>>> design/sba_hdr_mem.sv
`timescale 1ns / 1ps
// Block header RAM, one 64-bit word per 8 heap bytes, registered read.
// Contents are undefined until written; depends on sba_pkg for the word width.
module sba_hdr_mem #(
    parameter int ADDR_W = 21
) (
    input  logic                      i_clk,
    input  logic [ADDR_W-1:0]         i_rd_addr,
    input  logic                      i_wr_en,
    input  logic [ADDR_W-1:0]         i_wr_addr,
    input  logic [sba_pkg::HDR_W-1:0] i_wr_data,
    output logic [sba_pkg::HDR_W-1:0] o_rd_data
);
    import sba_pkg::*;

    logic [HDR_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule

>>> tb/sv/sba_alloc_checker.sv
`timescale 1ns / 1ps
// Response checker for the segregated bin allocator: tracks heap, class lists and headers.
// Depends on sba_pkg and the sba_req_if / sba_rsp_if interfaces.
module sba_alloc_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    sba_req_if   i_req_ch,
    sba_rsp_if   i_rsp_ch,
    output int   o_fail_count,
    output int   o_pending
);
    import sba_pkg::*;

    localparam int NCLS = 8 * CLASS_SHIFTS_DEF - 17;
    localparam longint unsigned HEAP_WORDS = 64'd1 << (HEAP_ADDR_BITS_DEF - 3);
    localparam longint unsigned HEAP_SPAN  = 64'd1 << HEAP_ADDR_BITS_DEF;

    typedef struct packed {
        t_status            status;
        logic [FIELD_W-1:0] addr;
        logic [FIELD_W-1:0] bytes;
    } t_answer;

    longint unsigned bin_bytes [NCLS];
    bit [63:0]       hdr_words [longint unsigned];
    bit [31:0]       list_head [NCLS];
    bit [31:0]       free_blocks [NCLS];
    bit [31:0]       served_blocks [NCLS];
    longint unsigned heap_top;
    t_answer         answers_due [$];

    function automatic void clear_heap();
        longint unsigned last;
        longint unsigned s;
        int n;
        last = 0;
        n = 0;
        for (int i = 0; i < CLASS_SHIFTS_DEF; i++) begin
            for (int j = 8; j <= 15; j++) begin
                s = longint'(j) << i;
                if (s >= last + 8 && n < NCLS) begin
                    bin_bytes[n] = s;
                    n++;
                    last = s;
                end
            end
        end
        hdr_words.delete();
        for (int c = 0; c < NCLS; c++) begin
            list_head[c] = 0;
            free_blocks[c] = 0;
            served_blocks[c] = 0;
        end
        heap_top = 0;
    endfunction

    function automatic bit [63:0] read_hdr(longint unsigned idx);
        return hdr_words.exists(idx) ? hdr_words[idx] : 64'd0;
    endfunction

    function automatic void push_free(int c, longint unsigned idx, longint unsigned real_sz);
        idx &= HEAP_WORDS - 1;
        hdr_words[idx] = {TAG_FREE, list_head[c][29:0], real_sz[31:0]};
        list_head[c] = 32'(idx + 1);
        free_blocks[c]++;
    endfunction

    function automatic longint unsigned pop_free(int c, output longint unsigned real_sz);
        longint unsigned idx;
        bit [63:0] w;
        idx = (longint'(list_head[c]) - 1) & (HEAP_WORDS - 1);
        w = read_hdr(idx);
        real_sz = w[31:0];
        list_head[c] = {2'b00, w[61:32]};
        free_blocks[c]--;
        return idx;
    endfunction

    function automatic int fit_bin_below(longint unsigned bytes);
        int m;
        m = 0;
        for (int i = 1; i < NCLS; i++)
            if (bin_bytes[i] <= bytes) m = i;
        return m;
    endfunction

    // Restock an empty list: a larger class with surplus blocks, else the largest
    // non-empty larger class, else a fresh chunk from the heap top.
    function automatic bit refill_bin(int c);
        longint unsigned lsize, idx, spare, real_sz, chunk;
        int src;
        lsize = bin_bytes[c];
        src = -1;
        for (int i = c + 1; i < NCLS && src < 0; i++)
            if (list_head[i] != 0 && free_blocks[i] > served_blocks[i]) src = i;
        for (int i = NCLS - 1; i > c && src < 0; i--)
            if (list_head[i] != 0) src = i;
        if (src >= 0) begin
            idx = pop_free(src, real_sz);
            spare = (real_sz > lsize) ? real_sz - lsize : 0;
        end else begin
            chunk = CHUNK_BYTES_DEF;
            if (lsize >= CHUNK_BYTES_DEF)
                chunk = ((lsize + CHUNK_BYTES_DEF - 1) / CHUNK_BYTES_DEF) * CHUNK_BYTES_DEF;
            if (heap_top + chunk > HEAP_SPAN) return 1'b0;
            idx = heap_top >> 3;
            heap_top += chunk;
            spare = chunk - lsize;
        end
        push_free(c, idx, lsize);
        if (spare >= 8) push_free(fit_bin_below(spare), idx + (lsize >> 3), spare);
        return 1'b1;
    endfunction

    function automatic t_answer predict_allocator_step(t_func f, logic [23:0] req,
                                                      logic [23:0] addr);
        t_answer a;
        longint unsigned need, real_sz, idx, slop, sz;
        bit [63:0] w;
        int c;
        a = '{status: ST_OK, addr: '0, bytes: '0};
        case (f)
            FN_ALLOC: begin
                need = longint'(req) + 8;
                if (need > bin_bytes[NCLS-1]) begin
                    a.status = ST_TOO_BIG;
                end else begin
                    c = 0;
                    while (bin_bytes[c] < need) c++;
                    if (list_head[c] == 0 && !refill_bin(c)) begin
                        a.status = ST_EXHAUSTED;
                    end else begin
                        idx = pop_free(c, real_sz);
                        slop = real_sz - req;
                        served_blocks[c]++;
                        if (real_sz < req || slop > SLOP_CAP) slop = SLOP_CAP;
                        hdr_words[idx] = {TAG_USED, 22'd0, 8'(c), slop[7:0], req};
                        a.addr = 24'((idx << 3) + 8);
                    end
                end
            end
            FN_FREE, FN_QUERY: begin
                if (f == FN_FREE && addr == 0) begin
                    a.status = ST_OK;
                end else if (addr < 8 || addr[2:0] != 0) begin
                    a.status = ST_BAD;
                end else begin
                    idx = (longint'(addr) - 8) >> 3;
                    w = read_hdr(idx);
                    sz = longint'(w[23:0]) + longint'(w[31:24]);
                    if (w[63:62] != TAG_USED || w[39:32] >= NCLS) a.status = ST_BAD;
                    else if (f == FN_FREE) push_free(int'(w[39:32]), idx, sz);
                    else a.bytes = 24'(sz);
                end
            end
            default: a.status = ST_BAD;
        endcase
        return a;
    endfunction

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_answer exp_a;
        if (!i_rst_n) begin
            clear_heap();
            answers_due.delete();
        end else begin
            if (i_req_ch.valid && i_req_ch.ready)
                answers_due.push_back(predict_allocator_step(t_func'(i_req_ch.func),
                    i_req_ch.request_size, i_req_ch.block_address));
            if (i_rsp_ch.valid && i_rsp_ch.ready) begin
                if (answers_due.size() == 0) begin
                    $error("response with no request outstanding");
                    o_fail_count++;
                end else begin
                    exp_a = answers_due.pop_front();
                    if (i_rsp_ch.status !== exp_a.status) begin
                        $error("status: expected %0d, got %0d", exp_a.status, i_rsp_ch.status);
                        o_fail_count++;
                    end
                    if (i_rsp_ch.result_address !== exp_a.addr) begin
                        $error("result_address: expected %0h, got %0h",
                               exp_a.addr, i_rsp_ch.result_address);
                        o_fail_count++;
                    end
                    if (i_rsp_ch.block_bytes !== exp_a.bytes) begin
                        $error("block_bytes: expected %0d, got %0d",
                               exp_a.bytes, i_rsp_ch.block_bytes);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending <= answers_due.size();
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request stimulus, response stalls, verdict.
// Depends on sba_pkg, the channel interfaces, the allocator RTL and sba_alloc_checker.
module tb_top;
    import sba_pkg::*;

    // A worst-case allocate walks every class several times; the watchdog allows far
    // longer than such an allocate takes without any handshake.
    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 1200;
    localparam int RANDOM_REQUESTS = 500;
    // Largest request that still fits the biggest class (15 MiB minus the header).
    localparam logic [23:0] MAX_FIT = 24'd15728632;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #4 i_clk = ~i_clk;

    sba_req_if req_ch ();
    sba_rsp_if rsp_ch ();

    segregated_bin_allocator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    int fail_count;
    int pending;

    sba_alloc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_ch     (req_ch),
        .i_rsp_ch     (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    // Addresses handed out by successful allocates and not yet retired. Their headers have
    // been written, so freeing or querying them never touches an uninitialized header word.
    logic [23:0] live_blocks [$];

    initial begin
        req_ch.valid = 1'b0;
        req_ch.func = FN_ALLOC;
        req_ch.request_size = '0;
        req_ch.block_address = '0;
        rsp_ch.ready = 1'b0;
    end

    // The response side stalls at the rate of the current phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Collect granted addresses so later free and size requests can target them.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == ST_OK &&
            rsp_ch.result_address != 0) begin
            live_blocks.push_back(rsp_ch.result_address);
        end
    end

    // Watchdog: ends the run when no handshake happens for too long.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Present one request and hold it until it is accepted. An idle gap, when the
    // phase calls for one, drops valid first; otherwise valid stays high back to back.
    task automatic issue(t_func f, logic [23:0] sz, logic [23:0] ad);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= f;
        req_ch.request_size <= sz;
        req_ch.block_address <= ad;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Stop sending and wait until every outstanding request has been answered.
    task automatic drain_answers();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [23:0] pick_block(bit retire);
        int k;
        logic [23:0] a;
        k = $urandom_range(live_blocks.size() - 1);
        a = live_blocks[k];
        if (retire) live_blocks.delete(k);
        return a;
    endfunction

    initial begin
        int r;
        logic [23:0] big_blk;
        logic [23:0] capped_blk;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling. The first allocate takes the largest class and
        // carves a 15 MiB chunk, so the identical second one finds the heap exhausted.
        issue(FN_ALLOC, MAX_FIT, 24'h000000);
        issue(FN_ALLOC, MAX_FIT, 24'hFFFFFF);
        issue(FN_ALLOC, MAX_FIT + 24'd1, 24'h000000);
        issue(FN_ALLOC, 24'hFFFFFF, 24'h000000);
        issue(FN_ALLOC, 24'd0, 24'h000000);
        issue(FN_ALLOC, 24'd1, 24'h000000);
        issue(FN_ALLOC, 24'd8, 24'h000000);
        issue(FN_ALLOC, 24'd9, 24'h000000);
        issue(FN_ALLOC, 24'd248, 24'h000000);
        // Slop beyond the cap gets clipped to 248.
        issue(FN_ALLOC, 24'd20000, 24'h000000);
        // Free of null is fine; null, unaligned addresses and the unused code are not.
        issue(FN_FREE, 24'd0, 24'd0);
        issue(FN_QUERY, 24'd0, 24'd0);
        issue(FN_QUERY, 24'd0, 24'd4);
        issue(FN_FREE, 24'd0, 24'd13);
        issue(FN_UNDEF, 24'hFFFFFF, 24'hFFFFFF);
        drain_answers();

        big_blk = live_blocks[0];
        capped_blk = live_blocks[live_blocks.size() - 1];
        issue(FN_QUERY, 24'd0, big_blk);
        issue(FN_FREE, 24'd0, big_blk);
        // A double free and a size request on a freed block both see a free header.
        issue(FN_FREE, 24'd0, big_blk);
        issue(FN_QUERY, 24'd0, big_blk);
        // The capped block goes back short of its class size; a larger request in the
        // same class then gets a block smaller than it asked for.
        issue(FN_FREE, 24'd0, capped_blk);
        issue(FN_ALLOC, 24'd20400, 24'd0);
        // An empty class is refilled by splitting the big freed block.
        issue(FN_ALLOC, 24'd5000, 24'd0);
        issue(FN_ALLOC, 24'd3, 24'd0);
        drain_answers();

        // Random part in four phases of idling: none, sender, receiver, both.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            case ((n / 50) % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 47; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 47; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            r = $urandom_range(99);
            if (r < 45 || live_blocks.size() == 0) begin
                r = $urandom_range(99);
                if (r < 80) begin
                    issue(FN_ALLOC, 24'($urandom_range(600)), 24'($urandom));
                end else if (r < 96) begin
                    issue(FN_ALLOC, 24'($urandom_range(8000)), 24'($urandom));
                end else begin
                    issue(FN_ALLOC, 24'($urandom_range(16777215, MAX_FIT + 1)),
                          24'($urandom));
                end
            end else if (r < 75) begin
                // Mostly retire the block; a kept one may later be freed twice.
                issue(FN_FREE, 24'($urandom), pick_block($urandom_range(99) < 70));
            end else if (r < 78) begin
                issue(FN_FREE, 24'($urandom), 24'd0);
            end else if (r < 83) begin
                issue(($urandom_range(1)) ? FN_FREE : FN_QUERY, 24'($urandom),
                      24'($urandom) | 24'd1);
            end else if (r < 96) begin
                issue(FN_QUERY, 24'($urandom), pick_block(1'b0));
            end else if (r < 98) begin
                issue(FN_QUERY, 24'($urandom), 24'($urandom_range(7)));
            end else begin
                issue(FN_UNDEF, 24'($urandom), 24'($urandom));
            end
        end

        drain_answers();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
design/sba_pkg.sv
design/sba_if.sv
design/sba_class_mem.sv
design/sba_hdr_mem.sv
design/segregated_bin_allocator.sv
tb/sv/sba_alloc_checker.sv
tb/sv/tb_top.sv
